@@ design/lrpc_pkg.sv @@
`timescale 1ns / 1ps
package lrpc_pkg;
  localparam int unsigned RingsDefault = 128;
  localparam int unsigned CoordW = 19;
  localparam int unsigned PointW = 3 * CoordW;
  localparam logic [2:0] RegPlaneA = 3'd0;
  localparam logic [2:0] RegPlaneB = 3'd1;
  localparam logic [2:0] RegPlaneC = 3'd2;
  localparam logic [2:0] RegOffset = 3'd3;
  localparam logic [2:0] RegLimit = 3'd4;
  localparam logic [2:0] RegWidth = 3'd5;
  localparam logic [2:0] RegTol = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;
endpackage

@@ design/lrpc_ram.sv @@
`timescale 1ns / 1ps
module lrpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/lrpc_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; floor division of a signed
// numerator by a positive denominator.
module lrpc_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [27:0] num_i,
  input  logic [8:0]         den_i,
  output logic               done_o,
  output logic signed [18:0] quo_o
);
  logic [27:0] rem_q, rem_d, mag_q, mag_d, quo_q, quo_d;
  logic [8:0]  den_q;
  logic        neg_q, busy_q, busy_d, done_q;
  logic [4:0]  cnt_q;
  logic [28:0] trial;
  logic [27:0] qfin;

  always_comb begin
    rem_d  = rem_q;
    mag_d  = mag_q;
    quo_d  = quo_q;
    busy_d = busy_q;
    trial  = {rem_q, mag_q[27]};
    if (busy_q) begin
      mag_d = {mag_q[26:0], 1'b0};
      if (trial >= {20'd0, den_q}) begin
        rem_d = 28'(trial - {20'd0, den_q});
        quo_d = {quo_q[26:0], 1'b1};
      end else begin
        rem_d = trial[27:0];
        quo_d = {quo_q[26:0], 1'b0};
      end
      if (cnt_q == 5'd27) busy_d = 1'b0;
    end
  end

  // floor for negatives: -(q) minus one when remainder nonzero
  assign qfin  = neg_q ? ((rem_q != '0) ? 28'(~quo_q) : 28'(-quo_q)) : quo_q;
  assign quo_o = qfin[18:0];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !busy_d;
      busy_q <= busy_d;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[27];
      mag_q <= num_i[27] ? 28'(-num_i) : num_i;
      rem_q <= '0;
      quo_q <= '0;
      den_q <= den_i;
    end else begin
      rem_q <= rem_d;
      mag_q <= mag_d;
      quo_q <= quo_d;
    end
  end
endmodule

@@ design/lidar_ring_plane_center.sv @@
`timescale 1ns / 1ps
// Board center finder over lidar rings. A point item runs a fixed pipeline:
// plane products, plane sum and compare, ring store read, update and write
// back, and the next point is taken only once write back is done, as the ring
// store read-modify-write allows one item in flight (no forwarding needed). An
// item that carries end_of_cloud then walks all RINGS entries, each ring
// through read, squared span products and check, and a 28-step divider
// forms the mean of x and then of y (skipped when no ring counts) before its
// result item appears. Input stays stalled until the result item is taken.
// Ring occupancy sits in flip-flops cleared at reset and by the walk; point
// slots live in one RAM of three points per ring, and their contents are
// only used under occupancy. Configure only while idle.
module lidar_ring_plane_center #(
  parameter int unsigned RINGS = lrpc_pkg::RingsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [18:0] px_i,
  input  logic signed [18:0] py_i,
  input  logic signed [18:0] pz_i,
  input  logic [6:0]  ring_id_i,
  input  logic        end_of_cloud_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [18:0] center_x_o,
  output logic signed [18:0] center_y_o,
  output logic [7:0]  rings_used_o,
  output logic        center_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [18:0] cfg_data_i
);
  import lrpc_pkg::*;

  localparam int unsigned AW = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int unsigned SlotW = 3 * PointW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul  = 4'd1;
  localparam logic [3:0] StSum  = 4'd2;
  localparam logic [3:0] StRd   = 4'd3;
  localparam logic [3:0] StUpd  = 4'd4;
  localparam logic [3:0] StWRd  = 4'd5;
  localparam logic [3:0] StWMul = 4'd6;
  localparam logic [3:0] StWChk = 4'd7;
  localparam logic [3:0] StDiv  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0] st_q, st_d;

  // configuration
  logic signed [15:0] pa_q, pb_q, pc_q;
  logic signed [18:0] poff_q;
  logic [9:0]  lim_q, tol_q;
  logic [11:0] bw_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= '0; pb_q <= '0; pc_q <= '0; poff_q <= '0;
      lim_q <= 10'd80; bw_q <= 12'd600; tol_q <= 10'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPlaneA: pa_q   <= cfg_data_i[15:0];
        RegPlaneB: pb_q   <= cfg_data_i[15:0];
        RegPlaneC: pc_q   <= cfg_data_i[15:0];
        RegOffset: poff_q <= cfg_data_i;
        RegLimit:  lim_q  <= cfg_data_i[9:0];
        RegWidth:  bw_q   <= cfg_data_i[11:0];
        RegTol:    tol_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // captured item
  point_t     pt_q;
  logic [6:0] ring_q;
  logic       last_q;
  logic signed [34:0] ma_q, mb_q, mc_q;
  logic       onp_q;
  logic [RINGS-1:0] hit1_q, hit2_q;
  logic [AW-1:0] widx_q;

  logic in_acc;
  assign in_stall_o = (st_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;

  logic ring_ok;
  assign ring_ok = ({1'b0, ring_q} < 8'(RINGS));
  logic [AW-1:0] ring_a;
  assign ring_a = ring_q[AW-1:0];

  // plane distance sum, exact
  logic signed [37:0] s_sum, s_abs;
  assign s_sum = 38'(ma_q) + 38'(mb_q) + 38'(mc_q) + 38'($signed({poff_q, 15'd0}));
  assign s_abs = s_sum[37] ? -s_sum : s_sum;

  // ring store: low, second, high point per ring
  logic             ram_we;
  logic [AW-1:0]    ram_wa, ram_ra;
  logic [SlotW-1:0] ram_wd, ram_rd;
  lrpc_ram #(.Width(SlotW), .Depth(RINGS)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );
  point_t lo_p, sec_p, hi_p;
  assign {lo_p, sec_p, hi_p} = ram_rd;
  assign ram_ra = (st_q == StRd) ? ring_a : widx_q;

  logic h1, h2;
  assign h1 = hit1_q[ring_a];
  assign h2 = hit2_q[ring_a];
  point_t nlo, nsec, nhi;
  always_comb begin
    nlo = lo_p; nsec = sec_p; nhi = hi_p;
    if (!h1) begin
      nlo = pt_q; nhi = pt_q;
    end else begin
      if (pt_q.y < lo_p.y) begin
        nsec = lo_p; nlo = pt_q;
      end else if (!h2 || pt_q.y < sec_p.y) begin
        nsec = pt_q;
      end
      if (pt_q.y > hi_p.y) nhi = pt_q;
    end
  end
  assign ram_we = (st_q == StUpd) && onp_q && ring_ok;
  assign ram_wa = ring_a;
  assign ram_wd = {nlo, nsec, nhi};

  // walk: span squared
  logic signed [19:0] dx, dy, dz;
  assign dx = 20'(sec_p.x) - 20'(hi_p.x);
  assign dy = 20'(sec_p.y) - 20'(hi_p.y);
  assign dz = 20'(sec_p.z) - 20'(hi_p.z);
  logic [39:0] qx_q, qy_q, qz_q;
  logic [41:0] span;
  assign span = 42'(qx_q) + 42'(qy_q) + 42'(qz_q);
  logic signed [13:0] lo_b;
  logic [12:0] hi_b;
  assign lo_b = 14'(bw_q) - 14'(tol_q);
  assign hi_b = 13'(bw_q) + 13'(tol_q);
  logic [13:0] lo_m;
  assign lo_m = lo_b[13] ? 14'd0 : lo_b;
  logic [25:0] lo_sq, hi_sq;
  assign lo_sq = lo_m[12:0] * lo_m[12:0];
  assign hi_sq = hi_b * hi_b;
  logic w_hit, pass;
  assign pass = w_hit && (lo_b[13] || span > 42'(lo_sq)) && (span < 42'(hi_sq));
  logic signed [19:0] wsx_q, wsy_q;
  logic signed [26:0] sumx_q, sumy_q;
  logic [7:0] n_q;
  logic       walk_last;
  assign walk_last = (widx_q == AW'(RINGS - 1));

  // averaging: x then y through one divider
  logic        dv_start, dv_done, dv_y_q;
  logic signed [27:0] dv_num;
  logic signed [18:0] dv_quo;
  assign dv_num = dv_y_q ? (28'(sumy_q) + 28'(n_q)) : (28'(sumx_q) + 28'(n_q));
  lrpc_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dv_start), .num_i(dv_num),
    .den_i({n_q, 1'b0}), .done_o(dv_done), .quo_o(dv_quo)
  );
  logic dv_run_q;
  assign dv_start = (st_q == StDiv) && !dv_run_q;

  logic signed [18:0] hcx_q, hcy_q;
  logic out_v_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_acc) st_d = StMul;
      StMul:  st_d = StSum;
      StSum:  st_d = StRd;
      StRd:   st_d = StUpd;
      StUpd:  st_d = last_q ? StWRd : StIdle;
      StWRd:  st_d = StWMul;
      StWMul: st_d = StWChk;
      StWChk: st_d = walk_last ? ((n_q != '0 || pass) ? StDiv : StOut) : StWRd;
      StDiv:  if (dv_done && dv_y_q) st_d = StOut;
      StOut:  if (out_v_q && !out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      hit1_q <= '0; hit2_q <= '0;
      widx_q <= '0; n_q <= '0; w_hit <= 1'b0;
      dv_run_q <= 1'b0; dv_y_q <= 1'b0;
      hcx_q <= '0; hcy_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      case (st_q)
        StUpd: begin
          if (ram_we) begin
            hit2_q[ring_a] <= h1;
            hit1_q[ring_a] <= 1'b1;
          end
          widx_q <= '0;
          n_q <= '0;
        end
        StWRd: begin
          w_hit <= hit2_q[widx_q];
          hit1_q[widx_q] <= 1'b0;
          hit2_q[widx_q] <= 1'b0;
        end
        StWChk: begin
          if (pass) n_q <= n_q + 8'd1;
          widx_q <= widx_q + AW'(1);
          dv_y_q <= 1'b0;
          dv_run_q <= 1'b0;
        end
        StDiv: begin
          if (dv_start) dv_run_q <= 1'b1;
          if (dv_done) begin
            dv_run_q <= 1'b0;
            dv_y_q <= 1'b1;
            if (dv_y_q) hcy_q <= dv_quo; else hcx_q <= dv_quo;
          end
        end
        StOut: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result: StOut raises valid once and holds until the item is taken
  logic out_sent_q;
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_q <= {px_i, py_i, pz_i};
      ring_q <= ring_id_i;
      last_q <= end_of_cloud_i;
      sumx_q <= '0; sumy_q <= '0;
    end
    if (st_q == StMul) begin
      ma_q <= pa_q * pt_q.x;
      mb_q <= pb_q * pt_q.y;
      mc_q <= pc_q * pt_q.z;
    end
    if (st_q == StSum) onp_q <= (s_abs < 38'({lim_q, 15'd0}));
    if (st_q == StWMul) begin
      qx_q <= 40'(dx * dx);
      qy_q <= 40'(dy * dy);
      qz_q <= 40'(dz * dz);
      wsx_q <= 20'(sec_p.x) + 20'(hi_p.x);
      wsy_q <= 20'(sec_p.y) + 20'(hi_p.y);
    end
    if (st_q == StWChk && pass) begin
      sumx_q <= sumx_q + 27'(wsx_q);
      sumy_q <= sumy_q + 27'(wsy_q);
    end
    out_sent_q <= out_v_q;
  end

  assign out_valid_o    = out_v_q;
  assign center_x_o     = hcx_q;
  assign center_y_o     = hcy_q;
  assign rings_used_o   = n_q;
  assign center_found_o = (n_q != '0) && (out_v_q || out_sent_q);

  // the store is written only while a point is being updated
  a_we_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> st_q == StUpd) else $error("ring store write outside update");
  // a result appears only after the walk
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(st_q) == StOut) else $error("stray result");
  // no item accepted while a result is offered
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> in_stall_o) else $error("item accepted during result");
endmodule

@@ test/tb_lidar_ring_plane_center.sv @@
`timescale 1ns / 1ps
module tb_lidar_ring_plane_center;
  import lrpc_pkg::*;

  localparam int unsigned NumRings = 128;
  localparam int unsigned IdleLimit = 4000;  // watchdog limit on cycles without a handshake
  localparam int unsigned SettleCycles = 50;  // extra wait in drain after the queues empty
  localparam int unsigned TailCycles = 400;

  typedef struct {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] z;
    logic [6:0] ring;
    logic last;
  } lidar_point_t;

  typedef struct {
    logic signed [18:0] cx;
    logic signed [18:0] cy;
    logic [7:0] used;
    logic found;
  } board_center_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [18:0] px = '0, py = '0, pz = '0;
  logic [6:0] ring_id = '0;
  logic end_of_cloud = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [18:0] center_x, center_y;
  logic [7:0] rings_used;
  logic center_found;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [18:0] cfg_data = '0;

  lidar_ring_plane_center i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .px_i(px), .py_i(py), .pz_i(pz), .ring_id_i(ring_id), .end_of_cloud_i(end_of_cloud),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .center_x_o(center_x), .center_y_o(center_y),
    .rings_used_o(rings_used), .center_found_o(center_found),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the register file
  longint pl_a = 0, pl_b = 0, pl_c = 0, pl_off = 0;
  longint lim_mm = 80, width_mm = 600, tol_mm = 100;

  // Shadow of the ring store
  logic [1:0] ring_cnt[NumRings];
  point_t low_pt[NumRings], sec_pt[NumRings], high_pt[NumRings];
  longint held_x = 0, held_y = 0;

  lidar_point_t points_pending[$];
  board_center_t centers_due[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint floor_div(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint clip19(longint v);
    if (v > 262143) return 262143;
    if (v < -262144) return -262144;
    return v;
  endfunction

  // Advance the shadow store by one accepted point; on the cloud end, walk the rings.
  task automatic absorb_point(input lidar_point_t it);
    point_t p;
    longint s, lo, hi, sum_x, sum_y, n, dx, dy, dz, sp;
    int r;
    board_center_t c;
    p.x = it.x;
    p.y = it.y;
    p.z = it.z;
    r = it.ring;
    s = pl_a * longint'(it.x) + pl_b * longint'(it.y) + pl_c * longint'(it.z)
        + pl_off * 32768;
    if (s < 0) s = -s;
    if (s < lim_mm * 32768) begin
      if (ring_cnt[r] == 2'd0) begin
        low_pt[r] = p;
        high_pt[r] = p;
        ring_cnt[r] = 2'd1;
      end else begin
        // ties leave the stored point in place
        if (p.y < low_pt[r].y) begin
          sec_pt[r] = low_pt[r];
          low_pt[r] = p;
        end else if (ring_cnt[r] == 2'd1 || p.y < sec_pt[r].y) begin
          sec_pt[r] = p;
        end
        if (p.y > high_pt[r].y) high_pt[r] = p;
        ring_cnt[r] = 2'd2;
      end
    end
    if (it.last) begin
      lo = width_mm - tol_mm;
      hi = width_mm + tol_mm;
      sum_x = 0;
      sum_y = 0;
      n = 0;
      for (int i = 0; i < NumRings; i++) begin
        if (ring_cnt[i] == 2'd2) begin
          dx = longint'(sec_pt[i].x) - longint'(high_pt[i].x);
          dy = longint'(sec_pt[i].y) - longint'(high_pt[i].y);
          dz = longint'(sec_pt[i].z) - longint'(high_pt[i].z);
          sp = dx * dx + dy * dy + dz * dz;
          if ((lo < 0 || sp > lo * lo) && sp < hi * hi) begin
            sum_x += longint'(sec_pt[i].x) + longint'(high_pt[i].x);
            sum_y += longint'(sec_pt[i].y) + longint'(high_pt[i].y);
            n++;
          end
        end
        ring_cnt[i] = 2'd0;
      end
      if (n > 0) begin
        held_x = floor_div(sum_x + n, 2 * n);
        held_y = floor_div(sum_y + n, 2 * n);
      end
      c.cx = held_x[18:0];
      c.cy = held_y[18:0];
      c.used = n[7:0];
      c.found = (n > 0);
      centers_due.insert(centers_due.size(), c);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[18:0];
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      RegPlaneA: pl_a = val;
      RegPlaneB: pl_b = val;
      RegPlaneC: pl_c = val;
      RegOffset: pl_off = val;
      RegLimit: lim_mm = val;
      RegWidth: width_mm = val;
      RegTol: tol_mm = val;
      default: ;
    endcase
  endtask

  task automatic push_point(input longint x, input longint y, input longint z,
                            input int r, input bit last);
    lidar_point_t it;
    it.x = 19'(clip19(x));
    it.y = 19'(clip19(y));
    it.z = 19'(clip19(z));
    it.ring = r[6:0];
    it.last = last;
    points_pending.insert(points_pending.size(), it);
  endtask

  task automatic push_noise(input bit last);
    lidar_point_t it;
    it.x = 19'($urandom_range(0, 19'h7ffff));
    it.y = 19'($urandom_range(0, 19'h7ffff));
    it.z = 19'($urandom_range(0, 19'h7ffff));
    it.ring = 7'($urandom_range(0, 127));
    it.last = last;
    points_pending.insert(points_pending.size(), it);
  endtask

  // One cloud of board-like rings placed on the current plane, with some noise mixed in.
  task automatic push_board_cloud(output int count);
    int nr, npts, r;
    int rsel[6];
    longint x0, y0, spanw, x, y, z, jit, jl;
    nr = $urandom_range(1, 6);
    for (int i = 0; i < 6; i++) rsel[i] = $urandom_range(0, 127);
    x0 = longint'($urandom_range(0, 200000)) - 100000;
    y0 = longint'($urandom_range(0, 200000)) - 100000;
    spanw = width_mm + $urandom_range(0, 2 * tol_mm + 60) - tol_mm - 30;
    if (spanw < 0) spanw = 0;
    npts = $urandom_range(nr, nr * 4);
    jl = lim_mm + 3;
    for (int k = 0; k < npts; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_noise(k == npts - 1);
      end else begin
        r = rsel[$urandom_range(0, nr - 1)];
        x = x0 + $urandom_range(0, 40) - 20;
        y = y0 + $urandom_range(0, spanw) - spanw / 2;
        z = longint'($urandom_range(0, 4000)) - 2000;
        jit = longint'($urandom_range(0, 2 * jl)) - jl;
        if (pl_c != 0) z = -(pl_a * x + pl_b * y + pl_off * 32768) / pl_c + jit;
        else if (pl_a != 0) x = -(pl_b * y + pl_c * z + pl_off * 32768) / pl_a + jit;
        push_point(x, y, z, r, k == npts - 1);
      end
    end
    count = npts;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (points_pending.size() != 0 || in_valid || centers_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input longint a, input longint b, input longint c,
                           input longint off, input longint lim, input longint w,
                           input longint tol, input int n_items);
    int sent, got;
    write_reg(RegPlaneA, a);
    write_reg(RegPlaneB, b);
    write_reg(RegPlaneC, c);
    write_reg(RegOffset, off);
    write_reg(RegLimit, lim);
    write_reg(RegWidth, w);
    write_reg(RegTol, tol);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        // broken cloud: pure noise, then an end mark
        got = $urandom_range(1, 8);
        for (int k = 0; k < got; k++) push_noise(k == got - 1);
      end else begin
        push_board_cloud(got);
      end
      sent += got;
    end
    drain();
  endtask

  // Driver: hold a stalled item, otherwise advance through bursts and gaps.
  int burst_left = 4, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_point('{x: px, y: py, z: pz, ring: ring_id, last: end_of_cloud});
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (points_pending.size() > 0) begin
          lidar_point_t it;
          it = points_pending.pop_front();
          px <= it.x;
          py <= it.y;
          pz <= it.z;
          ring_id <= it.ring;
          end_of_cloud <= it.last;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: switch mode each time the 6-bit phase counter wraps (free, sparse, heavy).
  logic [5:0] stall_phase = '0;
  int stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: check each accepted center against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (centers_due.size() == 0) begin
        $display("%0t: unexpected center x=%0d y=%0d used=%0d found=%0b", $time,
                 center_x, center_y, rings_used, center_found);
        errors++;
      end else begin
        board_center_t e;
        e = centers_due.pop_front();
        if (center_x !== e.cx) begin
          $display("%0t: center_x expected %0d got %0d", $time, e.cx, center_x);
          errors++;
        end
        if (center_y !== e.cy) begin
          $display("%0t: center_y expected %0d got %0d", $time, e.cy, center_y);
          errors++;
        end
        if (rings_used !== e.used) begin
          $display("%0t: rings_used expected %0d got %0d", $time, e.used, rings_used);
          errors++;
        end
        if (center_found !== e.found) begin
          $display("%0t: center_found expected %0b got %0b", $time, e.found, center_found);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb_lidar_ring_plane_center: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumRings; i++) ring_cnt[i] = 2'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset plane is all zero, so every point is on it.
    push_point(5, 7, 9, 0, 1);                   // lone point: nothing counts, held zero out
    push_point(0, 0, 0, 5, 0);                   // exactly two points: span collapses to zero
    push_point(0, 600, 0, 5, 0);
    push_point(0, 0, 0, 6, 0);                   // tie in y goes to the second slot
    push_point(0, 0, 0, 6, 0);
    push_point(0, 650, 0, 6, 0);
    push_point(-262144, 262143, -262144, 127, 0);
    push_point(262143, -262144, 262143, 127, 1);
    push_point(0, 0, 0, 10, 0);                  // span at the upper bound fails
    push_point(0, 0, 0, 10, 0);
    push_point(0, 700, 0, 10, 0);
    push_point(0, 0, 0, 11, 0);                  // span at the lower bound fails
    push_point(0, 0, 0, 11, 0);
    push_point(0, 500, 0, 11, 0);
    push_point(-3, -5, 0, 12, 0);                // just inside
    push_point(-3, -5, 0, 12, 0);
    push_point(-2, 694, 0, 12, 0);
    push_point(-3, -1001, 1, 20, 0);             // negative midpoint with a half in each coordinate
    push_point(-3, -1001, 1, 20, 0);
    push_point(-4, -400, 1, 20, 1);
    push_point(1, 1, 1, 33, 1);                  // empty cloud: previous center held
    drain();

    run_phase(0, 0, 32767, 1500, 80, 600, 100, 150);
    run_phase(0, 0, -32768, -40000, 1023, 4095, 1023, 140);
    run_phase(23170, 0, 23170, 0, 0, 0, 0, 40);
    run_phase(0, 0, -32768, -262144, 200, 1000, 1023, 130);
    run_phase(-32768, 32767, 0, 5000, 120, 800, 150, 130);
    run_phase(0, -32768, 32767, 262143, 60, 50, 300, 130);
    run_phase(16384, 0, 32767, -20000, 90, 600, 100, 130);

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && centers_due.size() == 0) begin
      $display("tb_lidar_ring_plane_center: done, clean");
    end else begin
      $display("tb_lidar_ring_plane_center: done, errors");
    end
    $finish;
  end
endmodule
